FILE: rtl/iso_date_to_epoch_days_assert.svh
// Assertion macros for the date-to-epoch-days block.
// Used by rtl/iso_date_to_epoch_days.sv; empty in synthesis builds.
`ifndef ISO_DATE_TO_EPOCH_DAYS_ASSERT_SVH
`define ISO_DATE_TO_EPOCH_DAYS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define IDE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed in date conversion pipeline");

// Next-cycle implication, checked out of reset.
`define IDE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed in date conversion pipeline");

`else

`define IDE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define IDE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

FILE: rtl/ide_pkg.sv
// Shared widths, constants and the month offset table for the date converter.
// No dependencies; imported by rtl/iso_date_to_epoch_days.sv.
`timescale 1ns / 1ps

package ide_pkg;

  localparam int CHAR_W    = 8;
  localparam int NUM_CHARS = 10;
  localparam int LEN_W     = 4;
  localparam int IN_DATA_W = 88;   // 10 chars + 4-bit length, padded to bytes
  localparam int DAYS_W    = 23;
  localparam int OUT_DATA_W = 24;

  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [LEN_W-1:0]  MIN_LENGTH = 4'd10;

  localparam int ERA_YEARS = 400;
  localparam int ERA_DAYS  = 146097;
  localparam int YEAR_DAYS = 365;
  // Epoch shift plus one era, since the pipeline carries era + 1.
  localparam int EPOCH_OFFSET = 719468 + ERA_DAYS;
  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x < 650.
  localparam int RECIP_25    = 41;
  localparam int RECIP_SHIFT = 10;

  // Days from March 1 to the first of the March-based month mp: (153*mp+2)/5.
  function automatic logic [8:0] month_base(input logic [3:0] mp);
    logic [8:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/iso_date_to_epoch_days.sv
// Streaming YYYY-MM-DD text to signed days since 1970-01-01 converter.
// Each item passes four register stages; a new transaction can be taken in
// every cycle while the output is not stalled, so throughput is one date per clock.
// The depth is set by the chain parse, era split, day-of-era sum and era
// multiply. A stage holds its item while the stage after it is full and stalled.
// Depends on ide_pkg and iso_date_to_epoch_days_assert.svh.
`timescale 1ns / 1ps

`include "iso_date_to_epoch_days_assert.svh"

module iso_date_to_epoch_days (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // char_0 [7:0] .. char_9 [79:72], text_length [83:80], zero [87:84]
  input  logic [ide_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // epoch_days [22:0], zero [23]
  output logic [ide_pkg::OUT_DATA_W-1:0] out_tdata,
  // date_valid [0]
  output logic [0:0]                     out_tuser
);
  import ide_pkg::*;

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------- Stage 1: parse and check ----------------
  logic [CHAR_W-1:0] ch [NUM_CHARS];
  logic [3:0]        dig [NUM_CHARS];
  logic [LEN_W-1:0]  text_length;
  logic              digits_ok, form_ok;
  logic [13:0]       year;
  logic [6:0]        month, day;
  logic              early;
  logic              s1_ok_nxt;
  logic [13:0]       s1_q_nxt;
  logic [3:0]        s1_mp_nxt;

  logic              s1_ok_r;
  logic [13:0]       s1_q_r;     // shifted year + 400, always positive
  logic [3:0]        s1_mp_r;
  logic [4:0]        s1_day_r;

  always_comb begin
    for (int i = 0; i < NUM_CHARS; i++) begin
      ch[i]  = in_tdata[CHAR_W*i +: CHAR_W];
      dig[i] = ch[i][3:0];
    end
    text_length = in_tdata[CHAR_W*NUM_CHARS +: LEN_W];

    digits_ok = 1'b1;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (i != 4 && i != 7) begin
        if (ch[i] < CHAR_ZERO || ch[i] > CHAR_NINE) digits_ok = 1'b0;
      end
    end
    form_ok = digits_ok && (ch[4] == CHAR_DASH) && (ch[7] == CHAR_DASH)
              && (text_length >= MIN_LENGTH);

    year  = 14'(dig[0]) * 14'd1000 + 14'(dig[1]) * 14'd100
          + 14'(dig[2]) * 14'd10 + 14'(dig[3]);
    month = 7'(dig[5]) * 7'd10 + 7'(dig[6]);
    day   = 7'(dig[8]) * 7'd10 + 7'(dig[9]);

    s1_ok_nxt = form_ok && (month >= 7'd1) && (month <= 7'd12)
                && (day >= 7'd1) && (day <= 7'd31);

    // January and February belong to the previous March-based year.
    early     = (month <= 7'd2);
    s1_q_nxt  = year + 14'(ERA_YEARS) - 14'(early);
    s1_mp_nxt = early ? 4'(month + 7'd9) : 4'(month - 7'd3);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ok_r  <= s1_ok_nxt;
      s1_q_r   <= s1_q_nxt;
      s1_mp_r  <= s1_mp_nxt;
      s1_day_r <= day[4:0];
    end
  end

  // ---------------- Stage 2: era split and day of year ----------------
  logic [15:0] recip_prod;
  logic [4:0]  s2_era1_nxt;
  logic [13:0] yoe_full;
  logic [8:0]  s2_doy_nxt;

  logic        s2_ok_r;
  logic [4:0]  s2_era1_r;   // era + 1
  logic [8:0]  s2_yoe_r;
  logic [8:0]  s2_doy_r;

  always_comb begin
    // q / 400 = (q / 16) / 25
    recip_prod  = 16'(s1_q_r[13:4]) * 16'(RECIP_25);
    s2_era1_nxt = recip_prod[RECIP_SHIFT +: 5];
    yoe_full    = s1_q_r - 14'(s2_era1_nxt) * 14'(ERA_YEARS);
    s2_doy_nxt  = month_base(s1_mp_r) + 9'(s1_day_r) - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ok_r   <= s1_ok_r;
      s2_era1_r <= s2_era1_nxt;
      s2_yoe_r  <= yoe_full[8:0];
      s2_doy_r  <= s2_doy_nxt;
    end
  end

  // ---------------- Stage 3: day of era ----------------
  logic [1:0]  cent;
  logic [17:0] s3_doe_nxt;

  logic        s3_ok_r;
  logic [4:0]  s3_era1_r;
  logic [17:0] s3_doe_r;

  always_comb begin
    priority if (s2_yoe_r >= 9'd300) cent = 2'd3;
    else if (s2_yoe_r >= 9'd200)     cent = 2'd2;
    else if (s2_yoe_r >= 9'd100)     cent = 2'd1;
    else                             cent = 2'd0;
    s3_doe_nxt = 18'(s2_yoe_r) * 18'(YEAR_DAYS) + 18'(s2_yoe_r[8:2]) - 18'(cent)
               + 18'(s2_doy_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ok_r   <= s2_ok_r;
      s3_era1_r <= s2_era1_r;
      s3_doe_r  <= s3_doe_nxt;
    end
  end

  // ---------------- Stage 4: era days and epoch shift ----------------
  logic [23:0]       sum;
  logic [DAYS_W-1:0] days_nxt;

  logic              ok_r;
  logic [DAYS_W-1:0] days_r;

  always_comb begin
    // Two's complement wraps to the right signed value in 24 bits.
    sum      = 24'(s3_era1_r) * 24'(ERA_DAYS) + 24'(s3_doe_r) - 24'(EPOCH_OFFSET);
    days_nxt = s3_ok_r ? sum[DAYS_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ok_r   <= s3_ok_r;
      days_r <= days_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {1'b0, days_r};
  assign out_tuser  = ok_r;

  `IDE_ASSERT_IMP(a_invalid_zero, clk, rst_n, v4_r && !ok_r, days_r == '0)
  `IDE_ASSERT_IMP(a_s1_range, clk, rst_n, v1_r && s1_ok_r,
                  s1_mp_r <= 4'd11 && s1_day_r != 5'd0)
  `IDE_ASSERT_IMP(a_yoe_range, clk, rst_n, v2_r && s2_ok_r,
                  s2_yoe_r < 9'd400 && s2_era1_r <= 5'd25)
  `IDE_ASSERT_IMP(a_empty_ready, clk, rst_n, !v1_r, in_tready)
  `IDE_ASSERT_NXT(a_hold_on_stall, clk, rst_n, v4_r && !out_tready,
                  v4_r && $stable(days_r) && $stable(ok_r))

endmodule
